// ===== design/fila_pkg.sv =====
package fila_pkg;

  localparam int IdW     = 6;
  localparam int StatusW = 2;
  localparam int CountW  = 7;
  localparam int ActW    = 2;

  localparam logic [ActW-1:0] ACT_CLAIM_ANY  = 2'd0;
  localparam logic [ActW-1:0] ACT_CLAIM_ID   = 2'd1;
  localparam logic [ActW-1:0] ACT_RELEASE    = 2'd2;

  localparam logic [StatusW-1:0] ST_OK         = 2'd0;
  localparam logic [StatusW-1:0] ST_NOT_FREE   = 2'd1;
  localparam logic [StatusW-1:0] ST_NOT_CLAIMED = 2'd2;

  typedef struct packed {
    logic [ActW-1:0] action;
    logic [IdW-1:0]  id_value;
  } req_t;

  typedef struct packed {
    logic [IdW-1:0]     granted_id;
    logic [StatusW-1:0] status;
    logic [CountW-1:0]  claimed_count;
  } rsp_t;

endpackage

// ===== design/free_id_list_allocator.sv =====
// Hands out identifiers 0..NUM_IDS-1 from a free list kept as a linked chain in a link
// memory, with a claimed mark per identifier in a second memory. After reset the block
// runs an initialization pass, one link entry per cycle, with busy held high. An item is
// taken when start is high and busy is low. Claim-any, release and the unused action code
// pass from acceptance through the memory reads and the execute state to a registered
// result; so does claim-specific when the named identifier is rejected or sits at the head
// of the list. Otherwise it walks down the list, each hop one read of the link memory. The
// result is shown for exactly one cycle with done_o high and cannot be held off; busy drops
// in that same cycle, so the next item may be started while the result is on the ports.
module free_id_list_allocator import fila_pkg::*; #(
  parameter int NUM_IDS = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  localparam int IW = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
  localparam int LW = $clog2(NUM_IDS + 1);
  localparam int CW = $clog2(NUM_IDS + 1);
  localparam logic [LW-1:0] EndMark = LW'(NUM_IDS);
  localparam logic [IW-1:0] LastIdx = IW'(NUM_IDS - 1);

  localparam logic [1:0] S_INIT = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_WALK = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [LW-1:0]   head_q, head_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [IW-1:0]   init_q, init_d;
  logic [LW-1:0]   cur_q, cur_d, prev_q, prev_d;
  logic [ActW-1:0] act_q;
  logic [IdW-1:0]  id_q;
  logic            done_q, done_d;
  rsp_t            rsp_q, rsp_d;

  logic [LW-1:0] link_mem [NUM_IDS];
  logic          mark_mem [NUM_IDS];

  logic          link_we, mark_we, mark_wdata;
  logic [IW-1:0] link_waddr, link_raddr, mark_waddr, mark_raddr;
  logic [LW-1:0] link_wdata, link_rdata_q;
  logic          mark_rdata_q;

  logic          accept;
  logic [IW-1:0] id_idx;
  logic          id_oor;

  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;
  assign id_idx = IW'(id_q);
  assign id_oor = (32'(id_q) >= 32'(NUM_IDS));

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    cnt_d      = cnt_q;
    init_d     = init_q;
    cur_d      = cur_q;
    prev_d     = prev_q;
    done_d     = 1'b0;
    rsp_d      = rsp_q;
    link_we    = 1'b0;
    link_waddr = init_q;
    link_wdata = LW'(init_q) + LW'(1);
    link_raddr = IW'(cur_q);
    mark_we    = 1'b0;
    mark_waddr = init_q;
    mark_wdata = 1'b0;
    mark_raddr = id_idx;
    case (state_q)
      S_INIT: begin
        link_we = 1'b1;
        mark_we = 1'b1;
        init_d  = init_q + IW'(1);
        if (init_q == LastIdx) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        link_raddr = IW'(head_q);
        mark_raddr = IW'(req_i.id_value);
        if (start) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d             = S_IDLE;
        done_d              = 1'b1;
        rsp_d.granted_id    = id_q;
        rsp_d.status        = ST_OK;
        rsp_d.claimed_count = CountW'(cnt_q);
        case (act_q)
          ACT_CLAIM_ANY: begin
            if (head_q == EndMark) begin
              rsp_d.granted_id = '0;
              rsp_d.status     = ST_NOT_FREE;
            end else begin
              rsp_d.granted_id    = IdW'(head_q);
              head_d              = link_rdata_q;
              mark_we             = 1'b1;
              mark_waddr          = IW'(head_q);
              mark_wdata          = 1'b1;
              cnt_d               = cnt_q + CW'(1);
              rsp_d.claimed_count = CountW'(cnt_d);
            end
          end
          ACT_CLAIM_ID: begin
            if (id_oor || mark_rdata_q || head_q == EndMark) begin
              rsp_d.status = ST_NOT_FREE;
            end else if (head_q == LW'(id_idx)) begin
              head_d              = link_rdata_q;
              mark_we             = 1'b1;
              mark_waddr          = id_idx;
              mark_wdata          = 1'b1;
              cnt_d               = cnt_q + CW'(1);
              rsp_d.claimed_count = CountW'(cnt_d);
            end else begin
              done_d     = 1'b0;
              state_d    = S_WALK;
              prev_d     = head_q;
              cur_d      = link_rdata_q;
              link_raddr = IW'(link_rdata_q);
            end
          end
          ACT_RELEASE: begin
            if (id_oor || !mark_rdata_q) begin
              rsp_d.status = ST_NOT_CLAIMED;
            end else begin
              link_we             = 1'b1;
              link_waddr          = id_idx;
              link_wdata          = head_q;
              head_d              = LW'(id_idx);
              mark_we             = 1'b1;
              mark_waddr          = id_idx;
              mark_wdata          = 1'b0;
              cnt_d               = cnt_q - CW'(1);
              rsp_d.claimed_count = CountW'(cnt_d);
            end
          end
          default: begin
            rsp_d.granted_id = '0;
          end
        endcase
      end
      S_WALK: begin
        rsp_d.granted_id    = id_q;
        rsp_d.claimed_count = CountW'(cnt_q);
        if (cur_q >= EndMark) begin
          state_d      = S_IDLE;
          done_d       = 1'b1;
          rsp_d.status = ST_NOT_FREE;
        end else if (cur_q == LW'(id_idx)) begin
          state_d             = S_IDLE;
          done_d              = 1'b1;
          rsp_d.status        = ST_OK;
          link_we             = 1'b1;
          link_waddr          = IW'(prev_q);
          link_wdata          = link_rdata_q;
          mark_we             = 1'b1;
          mark_waddr          = id_idx;
          mark_wdata          = 1'b1;
          cnt_d               = cnt_q + CW'(1);
          rsp_d.claimed_count = CountW'(cnt_d);
        end else begin
          prev_d     = cur_q;
          cur_d      = link_rdata_q;
          link_raddr = IW'(link_rdata_q);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_rdata_q <= link_mem[link_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (mark_we) begin
      mark_mem[mark_waddr] <= mark_wdata;
    end
    mark_rdata_q <= mark_mem[mark_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      head_q  <= '0;
      cnt_q   <= '0;
      init_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      init_q  <= init_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    prev_q <= prev_d;
    rsp_q  <= rsp_d;
    if (accept) begin
      act_q <= req_i.action;
      id_q  <= req_i.id_value;
    end
  end

  a_done_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= 32'(NUM_IDS))
    else $error("claimed count above id count");

  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= EndMark)
    else $error("head beyond end mark");

  a_claim_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_q.status == ST_OK && act_q == ACT_CLAIM_ANY)
      |-> cnt_q == CW'($past(cnt_q) + CW'(1)))
    else $error("successful claim did not bump count");

  a_init_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INIT) |-> (busy && !done_o))
    else $error("activity during init pass");

endmodule
